// ===== hw/rtl/cfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfrp_pkg
// Shared types and constants of the custody fill record parser.
// ----------------------------------------------------------------------------
package cfrp_pkg;

    localparam int ID_W           = 64;
    localparam int BYTE_W         = 8;
    localparam int SDNV_DIGIT_W   = 7;
    localparam int REASON_W       = 7;
    localparam int MAX_SDNV_BYTES = 10;
    localparam int CNT_W          = $clog2(MAX_SDNV_BYTES + 2);

    localparam logic [3:0] ACS_RECORD_TYPE = 4'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 144;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_STATUS = 2'd1,
        PH_DELTA  = 2'd2,
        PH_LENGTH = 2'd3
    } t_phase;

    // One classified input byte.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              type_ok;
        logic              sdnv_more;
        logic              last;
    } t_item;

    typedef struct packed {
        logic                fill_valid;
        logic [ID_W-1:0]     first_id;
        logic [ID_W-1:0]     last_id;
        logic                record_done;
        logic                record_ok;
        logic                custody_succeeded;
        logic [REASON_W-1:0] reason_code;
    } t_result;

endpackage

// ===== hw/rtl/cfrp_front.sv =====
// ----------------------------------------------------------------------------
// cfrp_front
// Input stage: takes a byte request, classifies it and registers it for the
// queue.
// ----------------------------------------------------------------------------
module cfrp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_valid,
    output logic                   o_s_ready,
    input  logic [7:0]             i_s_data,
    input  logic                   i_s_last,
    output logic                   o_push,
    output cfrp_pkg::t_item        o_item,
    input  logic                   i_q_ready
);
    import cfrp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign o_s_ready = !r_valid || i_q_ready;
    assign take      = i_s_valid && o_s_ready;
    assign o_push    = r_valid;
    assign o_item    = r_item;

    always_comb begin
        n_item.data      = i_s_data;
        n_item.type_ok   = (i_s_data[BYTE_W-1:BYTE_W-4] == ACS_RECORD_TYPE);
        n_item.sdnv_more = i_s_data[BYTE_W-1];
        n_item.last      = i_s_last;
        priority if (take) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hw/rtl/cfrp_queue.sv =====
// ----------------------------------------------------------------------------
// cfrp_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module cfrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfrp_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output cfrp_pkg::t_item o_item,
    input  logic            i_pop
);
    import cfrp_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_CW-1:0] n_count;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/cfrp_back.sv =====
// ----------------------------------------------------------------------------
// cfrp_back
// Record parser: header check, SDNV accumulation, fill computation and the
// result register.
// ----------------------------------------------------------------------------
module cfrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  cfrp_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output cfrp_pkg::t_result o_result
);
    import cfrp_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [ID_W-1:0]  r_acc;
    logic [ID_W-1:0]  n_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [ID_W-1:0]  r_prev;
    logic [ID_W-1:0]  n_prev;
    logic [ID_W-1:0]  r_cle;
    logic [ID_W-1:0]  n_cle;
    logic [BYTE_W-1:0] r_status;
    logic [BYTE_W-1:0] n_status;
    logic             r_failed;
    logic             n_failed;
    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_out;
    t_result          n_out;

    logic [CNT_W-1:0] cnt_inc;
    logic [ID_W-1:0]  acc_new;
    logic             fill;
    logic             ok;
    logic             produce;

    assign o_pop     = i_q_valid && (!r_out_valid || i_m_ready);
    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;
    assign cnt_inc   = r_cnt + 1'b1;
    assign acc_new   = {r_acc[ID_W-SDNV_DIGIT_W-1:0], i_item.data[SDNV_DIGIT_W-1:0]};

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_prev   = r_prev;
        n_cle    = r_cle;
        n_status = r_status;
        n_failed = r_failed;
        fill     = 1'b0;
        ok       = 1'b0;
        if (!r_failed) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (!i_item.type_ok) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_status = i_item.data;
                    n_phase  = PH_DELTA;
                end
                PH_DELTA, PH_LENGTH: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc > CNT_W'(MAX_SDNV_BYTES) ||
                        r_acc[ID_W-1:ID_W-SDNV_DIGIT_W] != '0) begin
                        n_failed = 1'b1;
                    end else if (i_item.sdnv_more) begin
                        n_acc = acc_new;
                    end else begin
                        if (r_phase == PH_DELTA) begin
                            n_cle   = acc_new + r_prev;
                            n_phase = PH_LENGTH;
                        end else begin
                            n_prev  = r_cle + acc_new - ID_W'(1);
                            fill    = 1'b1;
                            ok      = i_item.last;
                            n_phase = PH_DELTA;
                        end
                        n_acc = '0;
                        n_cnt = '0;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end

        produce                 = fill || i_item.last;
        n_out.fill_valid        = fill;
        n_out.first_id          = fill ? r_cle : '0;
        n_out.last_id           = fill ? n_prev : '0;
        n_out.record_done       = i_item.last;
        n_out.record_ok         = ok;
        n_out.custody_succeeded = i_item.last && n_status[BYTE_W-1];
        n_out.reason_code       = i_item.last ? n_status[REASON_W-1:0] : '0;

        if (i_item.last) begin
            n_phase  = PH_TYPE;
            n_acc    = '0;
            n_cnt    = '0;
            n_prev   = '0;
            n_cle    = '0;
            n_status = '0;
            n_failed = 1'b0;
        end

        priority if (o_pop && produce) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_cle       <= '0;
            r_status    <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_cnt    <= n_cnt;
                r_prev   <= n_prev;
                r_cle    <= n_cle;
                r_status <= n_status;
                r_failed <= n_failed;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_out <= n_out;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_phase == PH_TYPE && !r_failed && r_cnt == '0))
        else $error("record state not cleared after last byte");

    // an over-long SDNV leaves the count one past the limit, with the record failed
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_failed |-> (r_cnt <= CNT_W'(MAX_SDNV_BYTES)))
        else $error("SDNV byte count beyond limit");

    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.fill_valid || r_out.record_done))
        else $error("result with neither fill nor record end");

    a_ok_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.record_ok) |-> (r_out.fill_valid && r_out.record_done))
        else $error("record_ok without closing fill");

endmodule

// ===== hw/rtl/custody_fill_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// custody_fill_record_parser_unit
// Parses aggregate custody signal records into fills and a per-record status.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Contents
// s_axis    in   tvalid/tready        tdata[7:0] record byte, tlast final byte
// m_axis    out  tvalid/tready        tdata fill ids and status, tuser fill flag,
//                                     tlast record end
//
// One byte per cycle sustained while m_axis takes results; a byte that yields a
// result passes the input register and a queue entry before the result register.
// The 64-bit fill add in the parser sets the cycle time.
// Reset is synchronous, active low, and clears all control and record state.
// A stalled m_axis is absorbed by the four-entry queue and the input register
// before s_axis tready drops.
// ----------------------------------------------------------------------------
module custody_fill_record_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] data_byte
    input  logic [cfrp_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [63:0] first_id, [127:64] last_id, [128] record_ok,
    // [129] custody_succeeded, [136:130] reason_code, [143:137] zero
    output logic [cfrp_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] fill_valid
    output logic [0:0]                      o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import cfrp_pkg::*;

    logic    push;
    t_item   f_item;
    logic    q_ready;
    logic    q_valid;
    t_item   q_item;
    logic    pop;
    t_result result;

    cfrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_data  (i_s_axis_tdata),
        .i_s_last  (i_s_axis_tlast),
        .o_push    (push),
        .o_item    (f_item),
        .i_q_ready (q_ready)
    );

    cfrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    cfrp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {
        (M_TDATA_W - 2*ID_W - 2 - REASON_W)'(0),
        result.reason_code,
        result.custody_succeeded,
        result.record_ok,
        result.last_id,
        result.first_id
    };
    assign o_m_axis_tuser = result.fill_valid;
    assign o_m_axis_tlast = result.record_done;

endmodule

// ===== tb/sv/custody_fill_record_checker.sv =====
// ----------------------------------------------------------------------------
// custody_fill_record_checker
// Watches both stream channels of the custody fill record parser. Every
// accepted request byte goes through a local parser model. Each fill or
// record-end status it produces is queued and compared field by field
// against the next accepted output beat.
// ----------------------------------------------------------------------------
module custody_fill_record_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // [7:0] data_byte
    input  logic [cfrp_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [63:0] first_id, [127:64] last_id, [128] record_ok,
    // [129] custody_succeeded, [136:130] reason_code, [143:137] zero
    input  logic [cfrp_pkg::M_TDATA_W-1:0]  i_m_tdata,
    // [0] fill_valid
    input  logic [0:0]                      i_m_tuser,
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count
);

    import cfrp_pkg::*;

    localparam int PRINT_CAP = 40;
    localparam int REASON_LO = 2*ID_W + 2;

    t_phase              phase;
    logic [ID_W-1:0]     sdnv_acc;
    logic [3:0]          digit_count;
    logic [ID_W-1:0]     prev_right;
    logic [ID_W-1:0]     cur_left;
    logic [BYTE_W-1:0]   status;
    logic                failed;

    t_result             expected_q[$];
    t_result             want;
    int                  fail_count   = 0;
    int                  result_count = 0;
    int                  pending      = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      result_count, name, got, exp_val));
    endtask

    task automatic clear_record();
        phase       = PH_TYPE;
        sdnv_acc    = '0;
        digit_count = '0;
        prev_right  = '0;
        cur_left    = '0;
        status      = '0;
        failed      = 1'b0;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic    fill;
        logic    ok;
        t_result r;
        fill = 1'b0;
        ok   = 1'b0;
        r    = '0;
        if (!failed) begin
            case (phase)
                PH_TYPE: begin
                    if (b[7:4] != ACS_RECORD_TYPE)
                        failed = 1'b1;
                    else
                        phase = PH_STATUS;
                end
                PH_STATUS: begin
                    status = b;
                    phase  = PH_DELTA;
                end
                default: begin
                    digit_count = digit_count + 4'd1;
                    // too many digits, or the next shift would drop set bits
                    if (digit_count > MAX_SDNV_BYTES || sdnv_acc[ID_W-1:57] != '0) begin
                        failed = 1'b1;
                    end else begin
                        sdnv_acc = {sdnv_acc[56:0], b[SDNV_DIGIT_W-1:0]};
                        if (!b[7]) begin
                            if (phase == PH_DELTA) begin
                                cur_left = sdnv_acc + prev_right;
                                phase    = PH_LENGTH;
                            end else begin
                                prev_right = cur_left + sdnv_acc - 64'd1;
                                r.first_id = cur_left;
                                r.last_id  = prev_right;
                                fill       = 1'b1;
                                ok         = last;
                                phase      = PH_DELTA;
                            end
                            sdnv_acc    = '0;
                            digit_count = '0;
                        end
                    end
                end
            endcase
        end
        if (fill || last) begin
            r.fill_valid  = fill;
            r.record_done = last;
            r.record_ok   = last && ok;
            if (last) begin
                r.custody_succeeded = status[7];
                r.reason_code       = status[REASON_W-1:0];
            end
            expected_q.push_back(r);
            if (last)
                clear_record();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_record();
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                parse_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              result_count));
                end else begin
                    want = expected_q.pop_front();
                    check_field("fill_valid", 64'(i_m_tuser[0]), 64'(want.fill_valid));
                    check_field("first_id", i_m_tdata[ID_W-1:0], want.first_id);
                    check_field("last_id", i_m_tdata[2*ID_W-1:ID_W], want.last_id);
                    check_field("record_done", 64'(i_m_tlast), 64'(want.record_done));
                    check_field("record_ok", 64'(i_m_tdata[2*ID_W]), 64'(want.record_ok));
                    check_field("custody_succeeded", 64'(i_m_tdata[2*ID_W+1]),
                                64'(want.custody_succeeded));
                    check_field("reason_code", 64'(i_m_tdata[REASON_LO +: REASON_W]),
                                64'(want.reason_code));
                    check_field("pad", 64'(i_m_tdata[M_TDATA_W-1:REASON_LO+REASON_W]),
                                64'(0));
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/sv/custody_fill_record_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// custody_fill_record_parser_unit_tb
// Drives custody signal records into the parser: a short directed set, then
// random well-formed records with broken and noisy ones mixed in. Requests
// arrive in bursts with gaps and the output side stalls in changing modes.
// The checker does all prediction; this top reports the verdict.
// ----------------------------------------------------------------------------
module custody_fill_record_parser_unit_tb;

    import cfrp_pkg::*;

    localparam int RANDOM_BYTES = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        REC_GOOD,
        REC_BAD_TYPE,
        REC_HDR_END,
        REC_IN_SDNV,
        REC_AFTER_DELTA,
        REC_LONG_SDNV,
        REC_WIDE_SDNV,
        REC_NOISE
    } t_rec_kind;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_CHOKED
    } t_rx_mode;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    int                     fail_count;
    int                     pending;
    int                     result_count;

    logic [BYTE_W-1:0]      rec_q[$];
    int                     rec_live;
    int                     burst_left   = 0;
    int                     bytes_sent   = 0;
    int                     live_sent    = 0;
    int                     records_sent = 0;
    int                     cycles       = 0;
    t_rx_mode               rx_mode      = RX_OPEN;
    int                     rx_left      = 0;

    custody_fill_record_parser_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    custody_fill_record_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // output-side stall pattern
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(RX_OPEN, RX_CHOKED));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready <= (rx_left[2:0] < 3'd5);
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          k;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1, 2:    v = 64'($urandom_range(0, 15));
            3:       v = 64'($urandom_range(0, 20000));
            4:       v = 64'($urandom);
            5:       v = {$urandom, $urandom};
            6:       v = '1;
            7: begin
                k = $urandom_range(1, 63);
                v = (64'd1 << k) - 64'($urandom_range(0, 1));
            end
            8:       v = {1'b1, 31'($urandom), $urandom};
            default: v = 64'($urandom_range(0, 127));
        endcase
        return v;
    endfunction

    function automatic int sdnv_len(input logic [63:0] v);
        int n;
        n = 1;
        while (n < MAX_SDNV_BYTES && (v >> (7*n)) != 0)
            n++;
        return n;
    endfunction

    // most significant digit first; digits past bit 63 come out zero
    task automatic add_sdnv(input logic [63:0] v, input int len);
        for (int i = len - 1; i >= 0; i--)
            rec_q.push_back({(i != 0), 7'(v >> (7*i))});
    endtask

    task automatic add_value(input logic [63:0] v);
        int len;
        len = sdnv_len(v);
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(len, MAX_SDNV_BYTES);
        add_sdnv(v, len);
    endtask

    task automatic add_pairs(input int count);
        repeat (count) begin
            add_value(pick_value());
            add_value(pick_value());
        end
    endtask

    task automatic add_noise(input int count);
        repeat (count)
            rec_q.push_back(8'($urandom));
    endtask

    task automatic build_record(input t_rec_kind kind);
        int t;
        rec_q.delete();
        if (kind == REC_BAD_TYPE) begin
            t = $urandom_range(0, 14);
            if (t >= ACS_RECORD_TYPE)
                t++;
            rec_q.push_back({4'(t), 4'($urandom)});
        end else begin
            rec_q.push_back({ACS_RECORD_TYPE, 4'($urandom)});
        end
        if (kind != REC_BAD_TYPE && (kind != REC_HDR_END || $urandom_range(0, 1)))
            add_noise(1);
        rec_live = rec_q.size();
        case (kind)
            REC_GOOD:        add_pairs($urandom_range(1, 6));
            REC_BAD_TYPE:    add_noise($urandom_range(0, 6));
            REC_IN_SDNV: begin
                add_pairs($urandom_range(0, 2));
                if ($urandom_range(0, 1))
                    add_value(pick_value());
                repeat ($urandom_range(1, 3))
                    rec_q.push_back({1'b1, 7'($urandom)});
            end
            REC_AFTER_DELTA: begin
                add_pairs($urandom_range(0, 2));
                add_value(pick_value());
            end
            REC_LONG_SDNV: begin
                add_pairs($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    add_value(pick_value());
                add_sdnv(64'($urandom_range(0, 127)), $urandom_range(11, 13));
            end
            REC_WIDE_SDNV: begin
                add_pairs($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    add_value(pick_value());
                rec_q.push_back({1'b1, 7'($urandom_range(2, 127))});
                repeat (9)
                    rec_q.push_back({1'b1, 7'($urandom)});
            end
            REC_NOISE:       add_noise($urandom_range(1, 12));
            default:         ;
        endcase
        if (kind != REC_BAD_TYPE)
            rec_live = rec_q.size();
        if (kind == REC_LONG_SDNV || kind == REC_WIDE_SDNV)
            add_noise($urandom_range(0, 3));
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++) begin
            push_byte(rec_q[i], i == rec_q.size() - 1);
            if (i < rec_live || i == rec_q.size() - 1)
                live_sent++;
        end
        records_sent++;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length fill wraps last_id, status all ones
        rec_q = '{8'h4F, 8'hFF, 8'h00, 8'h00};
        rec_live = rec_q.size();
        send_record();
        // two fills, second length spans two digits
        rec_q = '{8'h40, 8'h00, 8'h05, 8'h03, 8'h7F, 8'h81, 8'h00};
        rec_live = rec_q.size();
        send_record();
        // wrong type
        rec_q = '{8'h5A, 8'h12};
        rec_live = 1;
        send_record();
        // ends on type byte
        rec_q = '{8'h40};
        rec_live = 1;
        send_record();
        // ends on status byte
        rec_q = '{8'h4C, 8'h8A};
        rec_live = rec_q.size();
        send_record();
        // ends right after a start delta
        rec_q = '{8'h40, 8'h33, 8'h05};
        rec_live = rec_q.size();
        send_record();
        // ends inside an SDNV
        rec_q = '{8'h40, 8'h01, 8'h81};
        rec_live = rec_q.size();
        send_record();

        live_sent = 0;
        while (live_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 99)) inside
                [0:64]:  build_record(REC_GOOD);
                [65:69]: build_record(REC_BAD_TYPE);
                [70:74]: build_record(REC_HDR_END);
                [75:79]: build_record(REC_IN_SDNV);
                [80:84]: build_record(REC_AFTER_DELTA);
                [85:89]: build_record(REC_LONG_SDNV);
                [90:94]: build_record(REC_WIDE_SDNV);
                default: build_record(REC_NOISE);
            endcase
            send_record();
        end
        s_tvalid <= 1'b0;
        // let the checker take the final request before watching its queue
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d records, %0d bytes, %0d results checked, %0d mismatches",
                 records_sent, bytes_sent, result_count, fail_count);
        $display("records mixed well-formed fills with bad type, truncation, long and wide SDNVs");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cfrp_pkg.sv
hw/rtl/cfrp_front.sv
hw/rtl/cfrp_queue.sv
hw/rtl/cfrp_back.sv
hw/rtl/custody_fill_record_parser_unit.sv
tb/sv/custody_fill_record_checker.sv
tb/sv/custody_fill_record_parser_unit_tb.sv
